### rtl/core/obbt_pkg.sv
// Shared constants, widths and word types for the oriented-box overlap pipeline.
// Used by every module in rtl/core; no dependencies of its own.
`default_nettype none

package obbt_pkg;

    // field formats
    localparam int COORD_BITS = 20;
    localparam int AXIS_BITS  = 16;
    localparam int HALF_BITS  = COORD_BITS - 1;
    localparam int AXIS_FRAC  = AXIS_BITS - 2;

    // internal widths, all full precision
    localparam int TW   = COORD_BITS + 1;          // center difference
    localparam int TQW  = TW + AXIS_BITS;          // t_k * a_ik
    localparam int TPW  = TQW + 2;                 // projected distance t . Ai
    localparam int PW   = 2 * AXIS_BITS;           // axis component product
    localparam int RW   = PW + 1;                  // rotation term R[i][j]
    localparam int ARW  = 2 * AXIS_BITS;           // |R| + 1
    localparam int EAW  = HALF_BITS + ARW;         // extent * |R|
    localparam int RADW = EAW + 2;                 // sum of radius terms
    localparam int TPL  = TPW / 2;                 // low split of tp
    localparam int TPH  = TPW - TPL;               // high split of tp
    localparam int PLW  = TPL + 1 + RW;            // low partial product
    localparam int PHW  = TPH + RW;                // high partial product
    localparam int DW   = TPW + RW + 2;            // distance on B and cross axes
    localparam int NAX  = 15;                      // candidate axes

    localparam logic [3:0] NO_AXIS = 4'd15;

    typedef struct packed {
        logic [3*COORD_BITS-1:0] a_center;
        logic [3*HALF_BITS-1:0]  a_half_size;
        logic [3*AXIS_BITS-1:0]  a_axis0;
        logic [3*AXIS_BITS-1:0]  a_axis1;
        logic [3*AXIS_BITS-1:0]  a_axis2;
        logic [3*COORD_BITS-1:0] b_center;
        logic [3*HALF_BITS-1:0]  b_half_size;
        logic [3*AXIS_BITS-1:0]  b_axis0;
        logic [3*AXIS_BITS-1:0]  b_axis1;
        logic [3*AXIS_BITS-1:0]  b_axis2;
    } t_in_word;

    typedef struct packed {
        logic       overlap;
        logic [3:0] separating_axis;
    } t_out_word;

endpackage

`default_nettype wire

### rtl/core/obb_pair_overlap_test.sv
// Top level of the oriented-box pair overlap test: pipeline control, output
// word register and first-separating-axis encoder. Depends on obbt_pkg,
// obbt_proj and obbt_sep.
//
// Usage: one box pair per input word on i_valid/o_stall/i_data, one result
// word per pair on o_valid/i_stall/o_data, in order. A word moves on a rising
// edge where valid is high and stall is low.
// Pipeline: seven register stages from the accepting edge to the result on
// o_data (three projection stages, three separation stages, output register).
// Throughput: one pair per cycle unless the pipeline is held by a stall;
// every stage is a register slice with its own valid bit, so bubbles pass
// through without cost.
// Stall: while the output word is valid and i_stall is high, the whole
// pipeline holds and o_stall is raised; nothing is lost or repeated.
// Reset (i_rst_n low, synchronous): all valid bits clear, the pipeline is
// empty and ready on the next cycle.
`default_nettype none

module obb_pair_overlap_test (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_valid,
    output logic                    o_stall,
    input  obbt_pkg::t_in_word      i_data,
    output logic                    o_valid,
    input  wire                     i_stall,
    output obbt_pkg::t_out_word     o_data
);
    import obbt_pkg::*;

    logic                  en;
    logic                  p_vld;
    logic signed [TPW-1:0] p_tp [3];
    logic signed [RW-1:0]  p_r  [3][3];
    logic [EAW-1:0]        p_ea [3][3][3];
    logic [EAW-1:0]        p_eb [3][3][3];
    logic [HALF_BITS-1:0]  p_ae [3];
    logic [HALF_BITS-1:0]  p_be [3];
    logic                  s_vld;
    logic [NAX-1:0]        s_flags;
    logic                  r_vld;
    t_out_word             r_out;
    t_out_word             n_out;

    // pipeline advances unless a finished word is held by the receiver
    assign en      = !r_vld || !i_stall;
    assign o_stall = !en;

    obbt_proj u_proj (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (i_valid),
        .i_data  (i_data),
        .o_vld   (p_vld),
        .o_tp    (p_tp),
        .o_r     (p_r),
        .o_ea    (p_ea),
        .o_eb    (p_eb),
        .o_ae    (p_ae),
        .o_be    (p_be)
    );

    obbt_sep u_sep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (p_vld),
        .i_tp    (p_tp),
        .i_r     (p_r),
        .i_ea    (p_ea),
        .i_eb    (p_eb),
        .i_ae    (p_ae),
        .i_be    (p_be),
        .o_vld   (s_vld),
        .o_flags (s_flags)
    );

    // lowest-numbered separating axis wins
    always_comb begin
        n_out.separating_axis = NO_AXIS;
        for (int n = NAX - 1; n >= 0; n--) begin
            if (s_flags[n]) begin
                n_out.separating_axis = 4'(n);
            end
        end
        n_out.overlap = (s_flags == '0);
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (en) begin
            r_vld <= s_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_vld;
    assign o_data  = r_out;

endmodule

`default_nettype wire

### rtl/core/obbt_proj.sv
// Front three pipeline stages: center difference, rotation matrix R, |R|+1,
// projected distances tp and all extent * |R| products. Depends on obbt_pkg.
`default_nettype none

module obbt_proj (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_en,
    input  wire                        i_vld,
    input  obbt_pkg::t_in_word         i_data,
    output logic                       o_vld,
    output logic signed [obbt_pkg::TPW-1:0] o_tp [3],
    output logic signed [obbt_pkg::RW-1:0]  o_r  [3][3],
    output logic [obbt_pkg::EAW-1:0]   o_ea [3][3][3],
    output logic [obbt_pkg::EAW-1:0]   o_eb [3][3][3],
    output logic [obbt_pkg::HALF_BITS-1:0] o_ae [3],
    output logic [obbt_pkg::HALF_BITS-1:0] o_be [3]
);
    import obbt_pkg::*;

    // unpacked input fields
    logic signed [COORD_BITS-1:0] ac [3];
    logic signed [COORD_BITS-1:0] bc [3];
    logic signed [AXIS_BITS-1:0]  au [3][3];
    logic signed [AXIS_BITS-1:0]  bu [3][3];
    logic [HALF_BITS-1:0]         ae [3];
    logic [HALF_BITS-1:0]         be [3];

    // stage 1
    logic                         r1_v;
    logic signed [TW-1:0]         r1_t  [3];
    logic signed [PW-1:0]         r1_p  [3][3][3];
    logic signed [AXIS_BITS-1:0]  r1_au [3][3];
    logic [HALF_BITS-1:0]         r1_ae [3];
    logic [HALF_BITS-1:0]         r1_be [3];
    logic signed [TW-1:0]         n1_t  [3];
    logic signed [PW-1:0]         n1_p  [3][3][3];

    // stage 2
    logic                         r2_v;
    logic signed [RW-1:0]         r2_r  [3][3];
    logic [ARW-1:0]               r2_ar [3][3];
    logic signed [TQW-1:0]        r2_tq [3][3];
    logic [HALF_BITS-1:0]         r2_ae [3];
    logic [HALF_BITS-1:0]         r2_be [3];
    logic signed [RW-1:0]         n2_r  [3][3];
    logic [ARW-1:0]               n2_ar [3][3];
    logic signed [TQW-1:0]        n2_tq [3][3];
    logic signed [RW-1:0]         rabs;

    // stage 3 next values
    logic signed [TPW-1:0]        n3_tp [3];
    logic [EAW-1:0]               n3_ea [3][3][3];
    logic [EAW-1:0]               n3_eb [3][3][3];

    // field unpack
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            ac[k]    = i_data.a_center[k*COORD_BITS +: COORD_BITS];
            bc[k]    = i_data.b_center[k*COORD_BITS +: COORD_BITS];
            ae[k]    = i_data.a_half_size[k*HALF_BITS +: HALF_BITS];
            be[k]    = i_data.b_half_size[k*HALF_BITS +: HALF_BITS];
            au[0][k] = i_data.a_axis0[k*AXIS_BITS +: AXIS_BITS];
            au[1][k] = i_data.a_axis1[k*AXIS_BITS +: AXIS_BITS];
            au[2][k] = i_data.a_axis2[k*AXIS_BITS +: AXIS_BITS];
            bu[0][k] = i_data.b_axis0[k*AXIS_BITS +: AXIS_BITS];
            bu[1][k] = i_data.b_axis1[k*AXIS_BITS +: AXIS_BITS];
            bu[2][k] = i_data.b_axis2[k*AXIS_BITS +: AXIS_BITS];
        end
    end

    // stage 1: center difference, component products of Ai . Bj
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n1_t[k] = TW'(bc[k]) - TW'(ac[k]);
        end
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                for (int k = 0; k < 3; k++) begin
                    n1_p[i][j][k] = au[i][k] * bu[j][k];
                end
            end
        end
    end

    // stage 2: R, |R|+1, components of t . Ai
    always_comb begin
        rabs = '0;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                n2_r[i][j] = RW'(r1_p[i][j][0]) + RW'(r1_p[i][j][1])
                           + RW'(r1_p[i][j][2]);
                rabs = (n2_r[i][j] < 0) ? -n2_r[i][j] : n2_r[i][j];
                n2_ar[i][j] = ARW'(rabs) + ARW'(1);
            end
            for (int k = 0; k < 3; k++) begin
                n2_tq[i][k] = TQW'(r1_t[k]) * TQW'(r1_au[i][k]);
            end
        end
    end

    // stage 3: tp sums, extent * |R| products
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n3_tp[i] = TPW'(r2_tq[i][0]) + TPW'(r2_tq[i][1]) + TPW'(r2_tq[i][2]);
        end
        for (int a = 0; a < 3; a++) begin
            for (int b = 0; b < 3; b++) begin
                for (int j = 0; j < 3; j++) begin
                    n3_ea[a][b][j] = EAW'(r2_ae[a]) * EAW'(r2_ar[b][j]);
                    n3_eb[a][b][j] = EAW'(r2_be[a]) * EAW'(r2_ar[b][j]);
                end
            end
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v  <= 1'b0;
            r2_v  <= 1'b0;
            o_vld <= 1'b0;
        end else if (i_en) begin
            r1_v  <= i_vld;
            r2_v  <= r1_v;
            o_vld <= r2_v;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_t  <= n1_t;
            r1_p  <= n1_p;
            r1_au <= au;
            r1_ae <= ae;
            r1_be <= be;
            r2_r  <= n2_r;
            r2_ar <= n2_ar;
            r2_tq <= n2_tq;
            r2_ae <= r1_ae;
            r2_be <= r1_be;
            o_tp  <= n3_tp;
            o_r   <= r2_r;
            o_ea  <= n3_ea;
            o_eb  <= n3_eb;
            o_ae  <= r2_ae;
            o_be  <= r2_be;
        end
    end

endmodule

`default_nettype wire

### rtl/core/obbt_sep.sv
// Back three pipeline stages: radii, distances along B and cross axes, and the
// fifteen strict separation flags. Depends on obbt_pkg.
`default_nettype none

module obbt_sep (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_en,
    input  wire                        i_vld,
    input  wire signed [obbt_pkg::TPW-1:0] i_tp [3],
    input  wire signed [obbt_pkg::RW-1:0]  i_r  [3][3],
    input  wire [obbt_pkg::EAW-1:0]    i_ea [3][3][3],
    input  wire [obbt_pkg::EAW-1:0]    i_eb [3][3][3],
    input  wire [obbt_pkg::HALF_BITS-1:0] i_ae [3],
    input  wire [obbt_pkg::HALF_BITS-1:0] i_be [3],
    output logic                       o_vld,
    output logic [obbt_pkg::NAX-1:0]   o_flags
);
    import obbt_pkg::*;

    // stage 4
    logic                   r4_v;
    logic [RADW-1:0]        r4_ra [3];
    logic [RADW-1:0]        r4_rb [3];
    logic [RADW-1:0]        r4_rx [3][3];
    logic [TPW-1:0]         r4_atp [3];
    logic signed [PHW-1:0]  r4_ph [3][3][3];
    logic signed [PLW-1:0]  r4_pl [3][3][3];
    logic [RADW-1:0]        n4_ra [3];
    logic [RADW-1:0]        n4_rb [3];
    logic [RADW-1:0]        n4_rx [3][3];
    logic [TPW-1:0]         n4_atp [3];
    logic signed [PHW-1:0]  n4_ph [3][3][3];
    logic signed [PLW-1:0]  n4_pl [3][3][3];
    logic signed [TPH-1:0]  tph;
    logic signed [TPL:0]    tpl;

    // stage 5
    logic                   r5_v;
    logic [2:0]             r5_fa;
    logic signed [DW-1:0]   r5_db [3];
    logic signed [DW-1:0]   r5_dx [3][3];
    logic [RADW-1:0]        r5_rb [3];
    logic [RADW-1:0]        r5_rx [3][3];
    logic [2:0]             n5_fa;
    logic signed [DW-1:0]   n5_db [3];
    logic signed [DW-1:0]   n5_dx [3][3];

    logic [NAX-1:0]         n6_flags;

    // tp[a] * R[b][j] rebuilt from its two partial products
    function automatic logic signed [DW-1:0] f_prod(
        input logic signed [PHW-1:0] ph,
        input logic signed [PLW-1:0] pl
    );
        logic signed [DW-1:0] hi;
        hi = DW'(ph);
        return (hi <<< TPL) + DW'(pl);
    endfunction

    // strict |d| > rad scaled by 2^F
    function automatic logic f_sep(
        input logic signed [DW-1:0] d,
        input logic [RADW-1:0]      rad
    );
        logic signed [DW:0] dd;
        logic signed [DW:0] rr;
        dd = (DW+1)'(d);
        rr = (DW+1)'(rad);
        rr = rr <<< AXIS_FRAC;
        return (dd > rr) || (dd < -rr);
    endfunction

    // stage 4: radii, |tp|, split products tp * R
    always_comb begin
        tph = '0;
        tpl = '0;
        for (int i = 0; i < 3; i++) begin
            n4_ra[i] = (RADW'(i_ae[i]) << (2 * AXIS_FRAC)) + RADW'(i_eb[0][i][0])
                     + RADW'(i_eb[1][i][1]) + RADW'(i_eb[2][i][2]);
            n4_rb[i] = (RADW'(i_be[i]) << (2 * AXIS_FRAC)) + RADW'(i_ea[0][0][i])
                     + RADW'(i_ea[1][1][i]) + RADW'(i_ea[2][2][i]);
            n4_atp[i] = (i_tp[i] < 0) ? TPW'(-i_tp[i]) : TPW'(i_tp[i]);
            for (int j = 0; j < 3; j++) begin
                n4_rx[i][j] = RADW'(i_ea[(i+1)%3][(i+2)%3][j])
                            + RADW'(i_ea[(i+2)%3][(i+1)%3][j])
                            + RADW'(i_eb[(j+1)%3][i][(j+2)%3])
                            + RADW'(i_eb[(j+2)%3][i][(j+1)%3]);
            end
        end
        for (int a = 0; a < 3; a++) begin
            tph = i_tp[a][TPW-1:TPL];
            tpl = {1'b0, i_tp[a][TPL-1:0]};
            for (int b = 0; b < 3; b++) begin
                for (int j = 0; j < 3; j++) begin
                    n4_ph[a][b][j] = PHW'(tph) * PHW'(i_r[b][j]);
                    n4_pl[a][b][j] = PLW'(tpl) * PLW'(i_r[b][j]);
                end
            end
        end
    end

    // stage 5: A-axis flags, distances along B axes and crosses
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n5_fa[i] = ((DW'(r4_atp[i]) << AXIS_FRAC) > DW'(r4_ra[i]));
        end
        for (int j = 0; j < 3; j++) begin
            n5_db[j] = f_prod(r4_ph[0][0][j], r4_pl[0][0][j])
                     + f_prod(r4_ph[1][1][j], r4_pl[1][1][j])
                     + f_prod(r4_ph[2][2][j], r4_pl[2][2][j]);
        end
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                n5_dx[i][j] = f_prod(r4_ph[(i+2)%3][(i+1)%3][j],
                                     r4_pl[(i+2)%3][(i+1)%3][j])
                            - f_prod(r4_ph[(i+1)%3][(i+2)%3][j],
                                     r4_pl[(i+1)%3][(i+2)%3][j]);
            end
        end
    end

    // stage 6: B and cross flags, joined with the A-axis flags
    always_comb begin
        n6_flags[2:0] = r5_fa;
        for (int j = 0; j < 3; j++) begin
            n6_flags[3 + j] = f_sep(r5_db[j], r5_rb[j]);
        end
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                n6_flags[6 + 3*i + j] = f_sep(r5_dx[i][j], r5_rx[i][j]);
            end
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v  <= 1'b0;
            r5_v  <= 1'b0;
            o_vld <= 1'b0;
        end else if (i_en) begin
            r4_v  <= i_vld;
            r5_v  <= r4_v;
            o_vld <= r5_v;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_ra   <= n4_ra;
            r4_rb   <= n4_rb;
            r4_rx   <= n4_rx;
            r4_atp  <= n4_atp;
            r4_ph   <= n4_ph;
            r4_pl   <= n4_pl;
            r5_fa   <= n5_fa;
            r5_db   <= n5_db;
            r5_dx   <= n5_dx;
            r5_rb   <= r4_rb;
            r5_rx   <= r4_rx;
            o_flags <= n6_flags;
        end
    end

endmodule

`default_nettype wire
